// ----- design/fmwm_pkg.sv -----
// Package for the FM synthesizer write/mute filter: item classes, command and
// result codes, total-level constants and the channel operator table.
// No dependencies.
`default_nettype none

package fmwm_pkg;

  localparam int CHIP_COUNT        = 2;
  localparam int CHANNELS_PER_CHIP = 9;
  localparam int MAX_VOICES        = 18;
  localparam int SLOTS_PER_CHIP    = CHANNELS_PER_CHIP * 2;
  localparam int LEVEL_DEPTH       = MAX_VOICES * 2;
  localparam int LVL_AW            = $clog2(LEVEL_DEPTH);
  localparam int VOICE_W           = 5;
  localparam int CH_W              = $clog2(CHANNELS_PER_CHIP);
  localparam int QDEPTH            = 2;
  localparam int QPW               = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW               = $clog2(QDEPTH + 1);

  localparam logic [7:0] TL_BASE_SLOT0 = 8'h40;
  localparam logic [7:0] TL_BASE_SLOT1 = 8'h43;
  localparam logic [7:0] TL_KEEP_MASK  = 8'hC0;
  localparam logic [7:0] TL_ATTEN      = 8'h3F;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_REINIT = 2'd2,
    CMD_MUTE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_REINIT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CLS_PASS,
    CLS_LEVEL,
    CLS_SELECT,
    CLS_REINIT,
    CLS_MUTE
  } cls_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    cls_e               cls;
    logic               chip;
    logic [7:0]         addr;
    logic [7:0]         data;
    logic [LVL_AW-1:0]  lvl_idx;
    logic [VOICE_W-1:0] mute_idx;
    logic               mute_on;
    logic               dual;
  } item_t;

  function automatic logic [7:0] op_offset(input logic [CH_W-1:0] ch);
    logic [7:0] r;
    case (ch)
      4'd0:    r = 8'd0;
      4'd1:    r = 8'd1;
      4'd2:    r = 8'd2;
      4'd3:    r = 8'd8;
      4'd4:    r = 8'd9;
      4'd5:    r = 8'd10;
      4'd6:    r = 8'd16;
      4'd7:    r = 8'd17;
      4'd8:    r = 8'd18;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] attenuate(input logic [7:0] raw, input logic muted);
    return muted ? ((raw & TL_KEEP_MASK) | TL_ATTEN) : raw;
  endfunction

endpackage

`default_nettype wire

// ----- design/fmwm_front.sv -----
// Front end of the write/mute filter: accepts items, decodes total-level
// addresses and voices, tracks current chip and dual flag. Uses fmwm_pkg.
`default_nettype none

module fmwm_front import fmwm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [23:0]  s_axis_tdata_i,
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         q_full_i,
  output logic              push_o,
  output item_t             item_o
);

  logic               cur_chip_q, cur_chip_d;
  logic               dual_q, dual_d;
  logic               accept;
  logic               push_req;
  cmd_e               cmd;
  logic [7:0]         reg_addr;
  logic [7:0]         data_byte;
  logic               chip_sel;
  logic [VOICE_W-1:0] voice;
  logic               mute_on;
  logic               hit;
  logic [CH_W-1:0]    hit_ch;
  logic               hit_slot;
  logic               v_ok;
  logic               v_chip;
  logic [CH_W-1:0]    v_ch;

  assign cmd       = cmd_e'(s_axis_tuser_i);
  assign reg_addr  = s_axis_tdata_i[7:0];
  assign data_byte = s_axis_tdata_i[15:8];
  assign chip_sel  = s_axis_tdata_i[16];
  assign voice     = s_axis_tdata_i[21:17];
  assign mute_on   = s_axis_tdata_i[22];

  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = accept && push_req;

  // Total-level address decode: nine independent compares per slot
  always_comb begin
    hit      = 1'b0;
    hit_ch   = '0;
    hit_slot = 1'b0;
    for (int ch = 0; ch < CHANNELS_PER_CHIP; ch++) begin
      if (reg_addr == TL_BASE_SLOT0 + op_offset(CH_W'(ch))) begin
        hit      = 1'b1;
        hit_ch   = CH_W'(ch);
        hit_slot = 1'b0;
      end
      if (reg_addr == TL_BASE_SLOT1 + op_offset(CH_W'(ch))) begin
        hit      = 1'b1;
        hit_ch   = CH_W'(ch);
        hit_slot = 1'b1;
      end
    end
  end

  assign v_ok   = (int'(voice) < CHIP_COUNT * CHANNELS_PER_CHIP) && (int'(voice) < MAX_VOICES);
  assign v_chip = (int'(voice) >= CHANNELS_PER_CHIP);
  assign v_ch   = v_chip ? CH_W'(voice - VOICE_W'(CHANNELS_PER_CHIP)) : CH_W'(voice);

  always_comb begin
    cur_chip_d     = cur_chip_q;
    dual_d         = dual_q;
    push_req       = 1'b1;
    item_o.cls     = CLS_PASS;
    item_o.chip    = cur_chip_q;
    item_o.addr    = reg_addr;
    item_o.data    = data_byte;
    item_o.lvl_idx = (cur_chip_q ? LVL_AW'(SLOTS_PER_CHIP) : LVL_AW'(0))
                     + LVL_AW'({hit_ch, hit_slot});
    item_o.mute_idx = (cur_chip_q ? VOICE_W'(CHANNELS_PER_CHIP) : VOICE_W'(0))
                      + VOICE_W'(hit_ch);
    item_o.mute_on = mute_on;
    unique case (cmd)
      CMD_WRITE: begin
        if (hit && (int'(cur_chip_q) < CHIP_COUNT)) item_o.cls = CLS_LEVEL;
      end
      CMD_SELECT: begin
        item_o.cls  = CLS_SELECT;
        item_o.chip = chip_sel;
        cur_chip_d  = chip_sel;
        if (chip_sel) dual_d = 1'b1;
      end
      CMD_REINIT: begin
        item_o.cls  = CLS_REINIT;
        item_o.chip = 1'b0;
        cur_chip_d  = 1'b0;
        dual_d      = 1'b0;
      end
      CMD_MUTE: begin
        push_req        = v_ok;
        item_o.cls      = CLS_MUTE;
        item_o.chip     = v_chip;
        item_o.addr     = TL_BASE_SLOT0 + op_offset(v_ch);
        item_o.lvl_idx  = (v_chip ? LVL_AW'(SLOTS_PER_CHIP) : LVL_AW'(0))
                          + LVL_AW'({v_ch, 1'b0});
        item_o.mute_idx = voice;
      end
      default: ;
    endcase
    item_o.dual = dual_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_chip_q <= 1'b0;
      dual_q     <= 1'b0;
    end else if (accept) begin
      cur_chip_q <= cur_chip_d;
      dual_q     <= dual_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/fmwm_queue.sv -----
// Short FIFO of classified items between front and back of the filter.
// Uses fmwm_pkg for the item type and depth.
`default_nettype none

module fmwm_queue import fmwm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  item_t           slot_q [QDEPTH];
  logic [QPW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  function automatic logic [QPW-1:0] ptr_next(input logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : QPW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= QCW'(cnt_q + 1'b1);
      else if (pop_i && !push_i) cnt_q <= QCW'(cnt_q - 1'b1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= QDEPTH) else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- design/fmwm_back.sv -----
// Back end of the filter: level store with valid bits, mute bits, execution
// register and output register. Uses fmwm_pkg.
`default_nettype none

module fmwm_back import fmwm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  item_t             q_item_i,
  output logic              pop_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  // level store: memory plus one valid bit per entry, reinit clears valid
  logic [7:0]              lvl_mem [LEVEL_DEPTH];
  logic [LEVEL_DEPTH-1:0]  lvl_vld_q;
  logic [MAX_VOICES-1:0]   mute_q;
  logic [LVL_AW-1:0]       idx1;
  logic [7:0]              rd0_q, rd1_q;
  logic                    rv0_q, rv1_q;

  item_t       exec_q;
  logic        exec_v_q;
  logic [7:0]  exec_val_q;
  logic        phase_q;
  logic        out_load;
  logic        exec_done;
  logic        exec_rdy;

  logic        out_v_q;
  logic        out_chip_q, out_last_q, out_dual_q;
  logic [7:0]  out_reg_q, out_val_q;
  kind_e       out_kind_q;

  kind_e       r_kind;
  logic        r_chip;
  logic [7:0]  r_reg, r_val;
  logic        r_last;

  assign out_load  = !out_v_q || m_axis_tready_i;
  assign exec_done = exec_v_q && out_load && ((exec_q.cls != CLS_MUTE) || phase_q);
  assign exec_rdy  = !exec_v_q || exec_done;
  assign pop_o     = q_valid_i && exec_rdy;
  // slot 1 entry of the pair; stays inside the store whenever lvl_idx does
  assign idx1      = {q_item_i.lvl_idx[LVL_AW-1:1], 1'b1};

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (q_item_i.cls == CLS_LEVEL) lvl_mem[q_item_i.lvl_idx] <= q_item_i.data;
      rd0_q <= lvl_mem[q_item_i.lvl_idx];
      rd1_q <= lvl_mem[idx1];
      rv0_q <= lvl_vld_q[q_item_i.lvl_idx];
      rv1_q <= lvl_vld_q[idx1];
      exec_q <= q_item_i;
      exec_val_q <= (q_item_i.cls == CLS_LEVEL)
                    ? attenuate(q_item_i.data, mute_q[q_item_i.mute_idx])
                    : q_item_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= '0;
      mute_q    <= '0;
    end else if (pop_o) begin
      case (q_item_i.cls)
        CLS_LEVEL:  lvl_vld_q[q_item_i.lvl_idx] <= 1'b1;
        CLS_REINIT: lvl_vld_q <= '0;
        CLS_MUTE:   mute_q[q_item_i.mute_idx] <= q_item_i.mute_on;
        default: ;
      endcase
    end
  end

  // result from the execution register; a mute change gives two
  always_comb begin
    r_kind = KIND_WRITE;
    r_chip = exec_q.chip;
    r_reg  = exec_q.addr;
    r_val  = exec_val_q;
    r_last = 1'b1;
    case (exec_q.cls)
      CLS_SELECT: begin
        r_kind = KIND_SELECT;
        r_reg  = '0;
        r_val  = '0;
      end
      CLS_REINIT: begin
        r_kind = KIND_REINIT;
        r_chip = 1'b0;
        r_reg  = '0;
        r_val  = '0;
      end
      CLS_MUTE: begin
        r_last = phase_q;
        if (phase_q) begin
          r_reg = exec_q.addr + (TL_BASE_SLOT1 - TL_BASE_SLOT0);
          r_val = attenuate(rv1_q ? rd1_q : 8'h00, exec_q.mute_on);
        end else begin
          r_val = attenuate(rv0_q ? rd0_q : 8'h00, exec_q.mute_on);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_v_q <= 1'b0;
      phase_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (exec_rdy) exec_v_q <= q_valid_i;
      if (exec_v_q && out_load && (exec_q.cls == CLS_MUTE)) phase_q <= !phase_q;
      if (exec_v_q && out_load)  out_v_q <= 1'b1;
      else if (m_axis_tready_i)  out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_v_q && out_load) begin
      out_kind_q <= r_kind;
      out_chip_q <= r_chip;
      out_reg_q  <= r_reg;
      out_val_q  <= r_val;
      out_last_q <= r_last;
      out_dual_q <= exec_q.dual;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'b0, out_dual_q, out_val_q, out_reg_q, out_chip_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  a_phase_only_mute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (exec_v_q && exec_q.cls == CLS_MUTE))
    else $error("second phase without a mute change");
  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_last_q) |-> (exec_v_q && phase_q))
    else $error("first result of a pair without its second pending");
  a_phase_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_v_q && exec_q.cls == CLS_MUTE && !phase_q && out_load) |=> (exec_v_q && phase_q))
    else $error("mute change left before its second result");

endmodule

`default_nettype wire

// ----- design/fm_synth_write_mute_filter.sv -----
// Write filter with per-voice mute in front of a two-chip FM synthesizer bus.
// Slave stream: tuser = command (write, chip select, reinit, mute change);
// tdata carries register address, value, chip number, voice and mute flag.
// Master stream: tuser = result kind, tlast marks the last result of an item,
// tdata carries chip, register, value and the dual-chip flag.
// Throughput: one item per cycle for writes, selects and reinits while the
// receiver takes results; a mute change holds the execution register until
// both its results are in the output register, and both its stored levels
// are read together through two memory read ports.
// Voices outside the store give no result. Total-level writes are stored
// raw and forwarded attenuated when their channel is muted.
// Reset clears chip, dual flag, mute bits and all level valid bits at once,
// so the store reads as zero straight away; no clearing pass is needed.
// When the receiver stalls the output register holds, the two-entry queue
// fills, and tready falls only once the queue is full.
// Uses fmwm_pkg, fmwm_front, fmwm_queue and fmwm_back.
`default_nettype none

module fm_synth_write_mute_filter import fmwm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: reg_addr[7:0], data_byte[15:8], chip_sel[16], voice[21:17], mute_on[22]
  input  wire logic [23:0]  s_axis_tdata_i,
  // tuser: command[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata: out_chip[0], out_reg[8:1], out_value[16:9], dual_active[17]
  output logic [23:0]       m_axis_tdata_o,
  // tuser: kind[1:0]
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  logic   push, q_full, q_valid, pop;
  item_t  push_item, q_item;

  fmwm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  fmwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  fmwm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for the FM synthesizer write/mute filter: drives items on the
// input stream, predicts every forwarded write in step, and checks the output stream.
// Depends on fmwm_pkg and fm_synth_write_mute_filter.
`timescale 1ns / 100ps

module testbench;
  import fmwm_pkg::*;

  localparam int TX_ITEMS_RANDOM = 880;
  localparam int TX_ITEMS_CALM   = 140;

  typedef struct {
    kind_e      kind;
    logic       chip;
    logic [7:0] addr;
    logic [7:0] value;
    logic       last;
    logic       dual;
  } fm_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // predictor state
  logic       chip_now;
  logic       dual_now;
  logic [7:0] raw_level [LEVEL_DEPTH];
  logic       voice_muted [MAX_VOICES];
  logic [7:0] ch_op [CHANNELS_PER_CHIP] = '{8'd0, 8'd1, 8'd2, 8'd8, 8'd9, 8'd10,
                                            8'd16, 8'd17, 8'd18};

  fm_write_t pending_writes [$];
  int        mismatches = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  int        rx_hold_left = 0;
  int        rx_stall_left = 0;

  fm_synth_write_mute_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40) begin
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] muted_level(logic [7:0] raw, logic muted);
    return muted ? ((raw & TL_KEEP_MASK) | TL_ATTEN) : raw;
  endfunction

  function automatic void queue_write(kind_e kind, logic chip, logic [7:0] addr,
                                      logic [7:0] value, logic last);
    fm_write_t w;
    w.kind  = kind;
    w.chip  = chip;
    w.addr  = addr;
    w.value = value;
    w.last  = last;
    w.dual  = dual_now;
    pending_writes.insert(pending_writes.size(), w);
  endfunction

  // Works out the forwarded writes for one accepted item and updates the shadow state
  function automatic void predict_filter_results(cmd_e cmd, logic [7:0] addr,
      logic [7:0] data, logic sel, logic [4:0] voice, logic mute);
    int         slot_pos;
    int         base;
    logic [7:0] fwd;
    slot_pos = -1;
    case (cmd)
      CMD_WRITE: begin
        for (int ch = 0; ch < CHANNELS_PER_CHIP; ch++) begin
          if (addr == TL_BASE_SLOT0 + ch_op[ch]) slot_pos = ch * 2;
          if (addr == TL_BASE_SLOT1 + ch_op[ch]) slot_pos = ch * 2 + 1;
        end
        fwd = data;
        if (slot_pos >= 0 && int'(chip_now) < CHIP_COUNT) begin
          raw_level[int'(chip_now) * SLOTS_PER_CHIP + slot_pos] = data;
          fwd = muted_level(data,
                            voice_muted[int'(chip_now) * CHANNELS_PER_CHIP + slot_pos / 2]);
        end
        queue_write(KIND_WRITE, chip_now, addr, fwd, 1'b1);
      end
      CMD_SELECT: begin
        chip_now = sel;
        if (sel) dual_now = 1'b1;
        queue_write(KIND_SELECT, sel, 8'h00, 8'h00, 1'b1);
      end
      CMD_REINIT: begin
        foreach (raw_level[i]) raw_level[i] = 8'h00;
        dual_now = 1'b0;
        chip_now = 1'b0;
        queue_write(KIND_REINIT, 1'b0, 8'h00, 8'h00, 1'b1);
      end
      default: begin
        // voices beyond the last chip are dropped without a trace
        if (int'(voice) < CHIP_COUNT * CHANNELS_PER_CHIP) begin
          voice_muted[voice] = mute;
          base = int'(voice) / CHANNELS_PER_CHIP * SLOTS_PER_CHIP
               + int'(voice) % CHANNELS_PER_CHIP * 2;
          queue_write(KIND_WRITE, 1'(int'(voice) / CHANNELS_PER_CHIP),
                      TL_BASE_SLOT0 + ch_op[int'(voice) % CHANNELS_PER_CHIP],
                      muted_level(raw_level[base], mute), 1'b0);
          queue_write(KIND_WRITE, 1'(int'(voice) / CHANNELS_PER_CHIP),
                      TL_BASE_SLOT1 + ch_op[int'(voice) % CHANNELS_PER_CHIP],
                      muted_level(raw_level[base + 1], mute), 1'b1);
        end
      end
    endcase
  endfunction

  // Offers one item, waits for it to be taken, then, with input idling on, may drop tvalid for a while
  task automatic send_item(cmd_e cmd, logic [7:0] addr, logic [7:0] data, logic sel,
                           logic [4:0] voice, logic mute);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {1'b0, mute, voice, sel, data, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_filter_results(cmd, addr, data, sel, voice, mute);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] level_addr(int ch, bit slot);
    return (slot ? TL_BASE_SLOT1 : TL_BASE_SLOT0) + ch_op[ch];
  endfunction

  // Mostly level writes and in-range mute changes; ignored voices do not count
  task automatic send_random_item(output bit counted);
    int         pick;
    cmd_e       cmd;
    logic [7:0] addr;
    logic [4:0] voice;
    pick    = $urandom_range(0, 99);
    addr    = 8'($urandom_range(0, 255));
    voice   = 5'($urandom_range(0, 17));
    counted = 1'b1;
    if (pick < 45) begin
      cmd  = CMD_WRITE;
      addr = level_addr($urandom_range(0, 8), 1'($urandom_range(0, 1)));
    end else if (pick < 65) begin
      cmd = CMD_WRITE;
    end else if (pick < 76) begin
      cmd = CMD_SELECT;
    end else if (pick < 79) begin
      cmd = CMD_REINIT;
    end else begin
      cmd = CMD_MUTE;
      if ($urandom_range(0, 9) == 0) begin
        voice   = 5'($urandom_range(18, 31));
        counted = 1'b0;
      end
    end
    send_item(cmd, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), voice,
              1'($urandom_range(0, 1)));
  endtask

  task automatic test_level_writes();
    send_item(CMD_WRITE, level_addr(0, 0), 8'hFF, 1'b0, 5'd0, 1'b0);
    send_item(CMD_WRITE, level_addr(8, 1), 8'h00, 1'b1, 5'd31, 1'b1);
    send_item(CMD_WRITE, level_addr(8, 0), 8'h5A, 1'b0, 5'd0, 1'b0);
    send_item(CMD_WRITE, 8'h00, 8'hFF, 1'b0, 5'd0, 1'b0);
    send_item(CMD_WRITE, 8'hFF, 8'h00, 1'b0, 5'd0, 1'b0);
    send_item(CMD_WRITE, 8'h46, 8'h12, 1'b0, 5'd0, 1'b0);
  endtask

  task automatic test_chip_select();
    send_item(CMD_SELECT, 8'h00, 8'h00, 1'b1, 5'd0, 1'b0);
    send_item(CMD_WRITE, level_addr(8, 1), 8'hA5, 1'b0, 5'd0, 1'b0);
    send_item(CMD_SELECT, 8'hFF, 8'hFF, 1'b0, 5'd31, 1'b1);
    send_item(CMD_WRITE, level_addr(4, 0), 8'hC3, 1'b0, 5'd0, 1'b0);
  endtask

  task automatic test_voice_mute();
    send_item(CMD_MUTE, 8'h00, 8'h00, 1'b0, 5'd0, 1'b1);
    send_item(CMD_WRITE, level_addr(0, 1), 8'h80, 1'b0, 5'd0, 1'b0);
    send_item(CMD_MUTE, 8'h00, 8'h00, 1'b0, 5'd17, 1'b1);
    send_item(CMD_MUTE, 8'h00, 8'h00, 1'b0, 5'd18, 1'b1);
    send_item(CMD_MUTE, 8'h00, 8'h00, 1'b0, 5'd31, 1'b0);
    send_item(CMD_MUTE, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0);
  endtask

  task automatic test_reinit();
    send_item(CMD_SELECT, 8'h00, 8'h00, 1'b1, 5'd0, 1'b0);
    send_item(CMD_REINIT, 8'hFF, 8'hFF, 1'b1, 5'd31, 1'b1);
    send_item(CMD_MUTE, 8'h00, 8'h00, 1'b0, 5'd9, 1'b1);
    send_item(CMD_WRITE, level_addr(0, 0), 8'h01, 1'b0, 5'd0, 1'b0);
  endtask

  task automatic test_random_traffic(int n);
    int count;
    bit counted;
    count = 0;
    while (count < n) begin
      send_random_item(counted);
      if (counted) count++;
    end
  endtask

  // Output held off long enough for the filter to back up and drop tready
  task automatic test_backpressure();
    bit counted;
    tx_idle_on = 1'b0;
    rx_hold_left = 120;
    repeat (30) send_random_item(counted);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_calm_traffic();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(TX_ITEMS_CALM);
  endtask

  // Output side: long hold-off first, then random stall bursts
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      rx_stall_left = $urandom_range(0, 4);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fm_write_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata_o, 0);
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tuser_o !== want.kind) report_mismatch("kind", m_axis_tuser_o, want.kind);
        if (m_axis_tdata_o[0] !== want.chip) report_mismatch("chip", m_axis_tdata_o[0], want.chip);
        if (m_axis_tdata_o[8:1] !== want.addr) begin
          report_mismatch("register", m_axis_tdata_o[8:1], want.addr);
        end
        if (m_axis_tdata_o[16:9] !== want.value) begin
          report_mismatch("value", m_axis_tdata_o[16:9], want.value);
        end
        if (m_axis_tdata_o[17] !== want.dual) report_mismatch("dual", m_axis_tdata_o[17], want.dual);
        if (m_axis_tlast_o !== want.last) report_mismatch("last", m_axis_tlast_o, want.last);
        if (m_axis_tdata_o[23:18] !== 6'd0) report_mismatch("pad bits", m_axis_tdata_o[23:18], 0);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("fm_synth_write_mute_filter: mismatch");
    $finish;
  end

  initial begin
    chip_now = 1'b0;
    dual_now = 1'b0;
    foreach (raw_level[i]) raw_level[i] = 8'h00;
    foreach (voice_muted[i]) voice_muted[i] = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_level_writes();
    test_chip_select();
    test_voice_mute();
    test_reinit();
    test_random_traffic(TX_ITEMS_RANDOM);
    test_backpressure();
    test_calm_traffic();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_writes.size() != 0) report_mismatch("left over", pending_writes.size(), 0);

    if (mismatches == 0) begin
      $display("fm_synth_write_mute_filter: match");
    end else begin
      $display("fm_synth_write_mute_filter: mismatch");
    end
    $finish;
  end

endmodule
